@@ sv/pmd_pkg.sv @@
// shared constants for the pid position motor drive block
// widths of the fixed-point fields, register indexes and loop limits
// no dependencies
package pmd_pkg;

  localparam int ADC_BITS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_AT_ZERO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_AT_FULL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POSITION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd5;

  localparam int TGT_W  = 7;
  localparam int POS_W  = 18;
  localparam int ERR_W  = 19;
  localparam int SUM_W  = 16;
  localparam int GAIN_W = 20;
  localparam int MUL_W  = 20;
  localparam int HI_W   = 23;
  localparam int ACC_W  = HI_W + MUL_W;
  localparam int DRV_W  = 24;
  localparam int FRAC_SHIFT = 16;
  localparam int RND_W  = ACC_W - FRAC_SHIFT;

  localparam int SUM_LIMIT  = 25600;
  localparam int POS_MAX    = 131071;
  localparam int DRV_MAX    = 8388607;
  localparam int RND_HALF   = 32768;
  localparam int BRAKE_LIM  = 256;

  localparam int RAW_FULL_RESET = 1023;

  localparam logic [TGT_W-1:0]      TARGET_RESET = 7'd50;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 20'sd9830;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 20'sd66;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 20'sd0;

endpackage

@@ sv/pmd_if.sv @@
// handshake channels of the pid position motor drive block
// sample input, result output and register write channel
// depends on pmd_pkg
interface pmd_sample_if #(parameter int ADC_BITS = pmd_pkg::ADC_BITS_DEF);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface pmd_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [pmd_pkg::POS_W-1:0]  position_now;
  logic signed [pmd_pkg::DRV_W-1:0]  drive_value;
  logic                              bridge_a_high;
  logic                              bridge_b_high;

  modport source (output valid, output position_now, output drive_value,
                  output bridge_a_high, output bridge_b_high, input ready);
  modport sink   (input valid, input position_now, input drive_value,
                  input bridge_a_high, input bridge_b_high, output ready);
endinterface

interface pmd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pmd_pkg::CFG_IDX_W-1:0]    index;
  logic [pmd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/pmd_div.sv @@
// restoring divider, one quotient bit per cycle
// unsigned num / den, quotient valid from the done pulse until the next start
// no package dependencies
module pmd_div #(
  parameter int NW = 26,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nq;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   shifted;
  logic          fits;

  // shift in the next numerator bit and try the subtraction
  assign shifted = {rem, nq[NW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      nq  <= {nq[NW-2:0], fits};
      rem <= fits ? DW'(shifted - {1'b0, dvs}) : shifted[DW-1:0];
    end
  end

  assign quo = nq;

endmodule

@@ sv/pmd_mac.sv @@
// bit-serial sum of three signed products, one multiplier bit per cycle
// shift-right accumulator, top bit of each multiplier has negative weight
// depends on pmd_pkg
module pmd_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [pmd_pkg::MUL_W-1:0]   mul_e,
  input  logic signed [pmd_pkg::MUL_W-1:0]   mul_s,
  input  logic signed [pmd_pkg::MUL_W-1:0]   mul_d,
  input  logic signed [pmd_pkg::GAIN_W-1:0]  gain_p,
  input  logic signed [pmd_pkg::GAIN_W-1:0]  gain_i,
  input  logic signed [pmd_pkg::GAIN_W-1:0]  gain_d,
  output logic                               done,
  output logic signed [pmd_pkg::ACC_W-1:0]   acc
);
  import pmd_pkg::*;

  localparam int CW = $clog2(MUL_W);

  logic                    busy;
  logic [CW-1:0]           cnt;
  logic [MUL_W-1:0]        sh_e;
  logic [MUL_W-1:0]        sh_s;
  logic [MUL_W-1:0]        sh_d;
  logic signed [HI_W-1:0]  hi;
  logic [MUL_W-1:0]        lo;
  logic signed [HI_W-1:0]  term_raw;
  logic signed [HI_W-1:0]  term;
  logic signed [HI_W-1:0]  psum;
  logic                    last;

  assign last = cnt == CW'(MUL_W - 1);

  always_comb begin
    term_raw = '0;
    if (sh_e[0]) term_raw = term_raw + HI_W'(gain_p);
    if (sh_s[0]) term_raw = term_raw + HI_W'(gain_i);
    if (sh_d[0]) term_raw = term_raw + HI_W'(gain_d);
    term = last ? -term_raw : term_raw;
    psum = hi + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_e <= mul_e;
      sh_s <= mul_s;
      sh_d <= mul_d;
      hi   <= '0;
      lo   <= '0;
    end else if (busy) begin
      sh_e <= sh_e >> 1;
      sh_s <= sh_s >> 1;
      sh_d <= sh_d >> 1;
      hi   <= {psum[HI_W-1], psum[HI_W-1:1]};
      lo   <= {psum[0], lo[MUL_W-1:1]};
    end
  end

  assign acc = {hi, lo};

endmodule

@@ sv/pid_position_motor_drive_core.sv @@
// pid position loop with h-bridge direction and brake, top level
// depends on pmd_pkg, pmd_if, pmd_div and pmd_mac
//
// channels: sample (sink) takes one raw position reading per transaction,
// result (source) returns position_now, drive_value and the two bridge pin
// levels, cfg (sink) writes one register per transaction and is always ready.
// registers: 0 raw_at_zero, 1 raw_at_full, 2 target_position, 3 gain_p,
// 4 gain_i, 5 gain_d; other indexes are ignored.
// steps: the taken sample is registered, then prep, the serial divider (ADC_BITS
// + 16 quotient bits, one per cycle), position, error, the serial
// multiply-accumulate (20 multiplier bits, one per cycle), rounding and the
// output register load.
// one sample at a time: the next sample is taken as soon as the
// previous result sits in the output register.
// a stalled receiver holds the result; a finished item then waits until the
// output register frees up, and no sample is taken meanwhile.
// reset (synchronous, active high) restores the register defaults and clears
// the error integral and the previous error.
module pid_position_motor_drive_core #(
  parameter int ADC_BITS = pmd_pkg::ADC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pmd_sample_if.sink    sample,
  pmd_cfg_if.sink       cfg,
  pmd_result_if.source  result
);
  import pmd_pkg::*;

  localparam int NW = ADC_BITS + 16;
  localparam int DW = ADC_BITS + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POS  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [ADC_BITS-1:0]       raw_at_zero;
  logic [ADC_BITS-1:0]       raw_at_full;
  logic [TGT_W-1:0]          target_position;
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;

  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;

  logic signed [ADC_BITS:0]  diff;
  logic signed [ADC_BITS:0]  den;
  logic                      quo_neg;
  logic                      den_zero;
  logic signed [POS_W-1:0]   position;
  logic [RND_W-1:0]          rnd_mag;
  logic                      drv_neg;

  logic                      out_valid;
  logic signed [POS_W-1:0]   out_position;
  logic signed [DRV_W-1:0]   out_drive;
  logic                      out_a;
  logic                      out_b;

  logic                      sample_take;
  logic                      out_load;

  // divider operands
  logic [ADC_BITS:0]         diff_abs;
  logic [ADC_BITS:0]         den_abs;
  logic [NW-1:0]             n_mag;
  logic [NW-1:0]             div_num;
  logic [DW-1:0]             div_den;
  logic                      div_done;
  logic [NW-1:0]             div_quo;

  logic signed [POS_W-1:0]   pos_next;

  logic signed [ERR_W-1:0]   err;
  logic signed [MUL_W-1:0]   sum_wide;
  logic signed [SUM_W-1:0]   sum_clamp;
  logic signed [MUL_W-1:0]   deriv;
  logic                      mac_done;
  logic signed [ACC_W-1:0]   acc;

  logic [ACC_W-1:0]          rnd_sum;
  logic [RND_W-1:0]          rnd_neg_mag;
  logic signed [DRV_W-1:0]   drive_next;
  logic                      brake;

  assign sample.ready = state == ST_IDLE;
  assign sample_take  = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_at_zero     <= '0;
      raw_at_full     <= ADC_BITS'(RAW_FULL_RESET);
      target_position <= TARGET_RESET;
      gain_p          <= GAIN_P_RESET;
      gain_i          <= GAIN_I_RESET;
      gain_d          <= GAIN_D_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_RAW_AT_ZERO:     raw_at_zero     <= cfg.data[ADC_BITS-1:0];
        CFG_RAW_AT_FULL:     raw_at_full     <= cfg.data[ADC_BITS-1:0];
        CFG_TARGET_POSITION: target_position <= cfg.data[TGT_W-1:0];
        CFG_GAIN_P:          gain_p          <= signed'(cfg.data[GAIN_W-1:0]);
        CFG_GAIN_I:          gain_i          <= signed'(cfg.data[GAIN_W-1:0]);
        CFG_GAIN_D:          gain_d          <= signed'(cfg.data[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // position mapping: ((2n + d) / 2d) gives round half away from zero
  always_comb begin
    diff_abs = diff[ADC_BITS] ? -diff : diff;
    den_abs  = den[ADC_BITS] ? -den : den;
    n_mag    = (NW'(diff_abs[ADC_BITS-1:0]) << 14) + (NW'(diff_abs[ADC_BITS-1:0]) << 13)
             + (NW'(diff_abs[ADC_BITS-1:0]) << 10);
    div_num  = (n_mag << 1) + NW'(den_abs[ADC_BITS-1:0]);
    div_den  = {den_abs[ADC_BITS-1:0], 1'b0};
  end

  pmd_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (den_zero) begin
      pos_next = '0;
    end else if (quo_neg) begin
      if (div_quo > NW'(POS_MAX + 1)) begin
        pos_next = POS_W'(-(POS_MAX + 1));
      end else begin
        pos_next = -signed'(div_quo[POS_W-1:0]);
      end
    end else begin
      if (div_quo > NW'(POS_MAX)) begin
        pos_next = POS_W'(POS_MAX);
      end else begin
        pos_next = signed'(div_quo[POS_W-1:0]);
      end
    end
  end

  // error, clamped integral and derivative
  always_comb begin
    err      = signed'({4'b0, target_position, 8'b0}) - {position[POS_W-1], position};
    sum_wide = {{(MUL_W - SUM_W){error_sum[SUM_W-1]}}, error_sum} + {err[ERR_W-1], err};
    if (sum_wide >= MUL_W'(SUM_LIMIT)) begin
      sum_clamp = SUM_W'(SUM_LIMIT);
    end else if (sum_wide < MUL_W'(-SUM_LIMIT)) begin
      sum_clamp = SUM_W'(-SUM_LIMIT);
    end else begin
      sum_clamp = sum_wide[SUM_W-1:0];
    end
    deriv = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  end

  pmd_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_ERR),
    .mul_e  ({err[ERR_W-1], err}),
    .mul_s  ({{(MUL_W - SUM_W){sum_clamp[SUM_W-1]}}, sum_clamp}),
    .mul_d  (deriv),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .done   (mac_done),
    .acc    (acc)
  );

  // magnitude plus half, then drop the 16 fraction bits
  assign rnd_sum = acc[ACC_W-1] ? (~acc + ACC_W'(RND_HALF + 1)) : (acc + ACC_W'(RND_HALF));

  always_comb begin
    rnd_neg_mag = ~rnd_mag + RND_W'(1);
    if (drv_neg) begin
      if (rnd_mag > RND_W'(DRV_MAX + 1)) begin
        drive_next = DRV_W'(-(DRV_MAX + 1));
      end else begin
        drive_next = signed'(rnd_neg_mag[DRV_W-1:0]);
      end
    end else begin
      if (rnd_mag > RND_W'(DRV_MAX)) begin
        drive_next = DRV_W'(DRV_MAX);
      end else begin
        drive_next = signed'(rnd_mag[DRV_W-1:0]);
      end
    end
    brake = rnd_mag < RND_W'(BRAKE_LIM);
  end

  assign out_load = (state == ST_OUT) && (!out_valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_take) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_POS;
      ST_POS:  state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  if (mac_done) state_next = ST_RND;
      ST_RND:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      error_sum      <= '0;
      previous_error <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ERR) begin
        error_sum      <= sum_clamp;
        previous_error <= err;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      diff <= signed'({1'b0, sample.adc_sample}) - signed'({1'b0, raw_at_zero});
      den  <= signed'({1'b0, raw_at_full}) - signed'({1'b0, raw_at_zero});
    end
    if (state == ST_PREP) begin
      quo_neg  <= diff[ADC_BITS] ^ den[ADC_BITS];
      den_zero <= den == '0;
    end
    if (state == ST_POS) begin
      position <= pos_next;
    end
    if (state == ST_RND) begin
      rnd_mag <= rnd_sum[ACC_W-1:FRAC_SHIFT];
      drv_neg <= acc[ACC_W-1];
    end
    if (out_load) begin
      out_position <= position;
      out_drive    <= drive_next;
      out_a        <= brake || !drv_neg;
      out_b        <= brake || drv_neg;
    end
  end

  assign result.valid         = out_valid;
  assign result.position_now  = out_position;
  assign result.drive_value   = out_drive;
  assign result.bridge_a_high = out_a;
  assign result.bridge_b_high = out_b;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_mac_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_MUL)
    else $error("multiply-accumulate finished outside its wait state");

  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    error_sum <= SUM_W'(SUM_LIMIT) && error_sum >= SUM_W'(-SUM_LIMIT))
    else $error("error integral outside its clamp");

  a_bridge_never_float: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.bridge_a_high || result.bridge_b_high))
    else $error("both bridge inputs low");

endmodule
